### hw/rtl/ddn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_pkg: shared types and constants for the waypoint navigator
// Widths, fixed-point constants, CORDIC angle table and sequencer states.
// ----------------------------------------------------------------------------
package ddn_pkg;

	localparam int ROUTE_LENGTH = 4;
	localparam int CORDIC_STEPS = 16;

	// datapath widths
	localparam int XW  = 48;	// CORDIC x/y
	localparam int ZW  = 21;	// CORDIC angle, Q.16 rad
	localparam int MAW = 40;	// multiplier operand a
	localparam int MBW = 21;	// multiplier operand b
	localparam int MPW = MAW + MBW;

	localparam logic signed [MBW-1:0] TICK_K      = 21'sd14980;
	localparam logic signed [17:0]    PI_WRAP     = 18'sd25735;
	localparam logic signed [17:0]    TWO_PI_WRAP = 18'sd51470;
	localparam logic signed [ZW-1:0]  PI_Q16      = 21'sd205887;
	localparam logic signed [ZW-1:0]  HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [MBW-1:0] CORDIC_KINV = 21'sd636751;

	typedef enum logic [2:0] {
		CFG_ROUTE_X   = 3'd0,
		CFG_ROUTE_Y   = 3'd1,
		CFG_DIST_GAIN = 3'd2,
		CFG_HEAD_GAIN = 3'd3,
		CFG_ARRIVE    = 3'd4,
		CFG_DIST_CAP  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HEAD, ST_ROT, ST_MX1, ST_MX2, ST_MY1, ST_MY2, ST_ARRIVE,
		ST_AIM, ST_VEC, ST_MAG, ST_CAP, ST_BASE, ST_TURN, ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic vector_mode;
	} cordic_ctl_t;

	// arctangent table, Q.16 rad; zero past index 16
	function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0:    v = 21'sd51472;
			5'd1:    v = 21'sd30386;
			5'd2:    v = 21'sd16055;
			5'd3:    v = 21'sd8150;
			5'd4:    v = 21'sd4091;
			5'd5:    v = 21'sd2047;
			5'd6:    v = 21'sd1024;
			5'd7:    v = 21'sd512;
			5'd8:    v = 21'sd256;
			5'd9:    v = 21'sd128;
			5'd10:   v = 21'sd64;
			5'd11:   v = 21'sd32;
			5'd12:   v = 21'sd16;
			5'd13:   v = 21'sd8;
			5'd14:   v = 21'sd4;
			5'd15:   v = 21'sd2;
			5'd16:   v = 21'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ddn_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_if: tick and result channels
// Valid/ready channels carrying one control tick and one result.
// ----------------------------------------------------------------------------
interface ddn_tick_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] forward_speed;
	logic signed [15:0] turn_rate;
	modport source(output valid, forward_speed, turn_rate, input ready);
	modport sink(input valid, forward_speed, turn_rate, output ready);
endinterface

interface ddn_result_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] left_effort;
	logic signed [11:0] right_effort;
	logic               drive_active;
	logic               waypoint_reached;
	logic               route_done;
	logic signed [23:0] pose_x;
	logic signed [23:0] pose_y;
	logic signed [15:0] pose_heading;
	modport source(output valid, left_effort, right_effort, drive_active, waypoint_reached,
		route_done, pose_x, pose_y, pose_heading, input ready);
	modport sink(input valid, left_effort, right_effort, drive_active, waypoint_reached,
		route_done, pose_x, pose_y, pose_heading, output ready);
endinterface
`default_nettype wire

### hw/rtl/ddn_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_mul: shared signed multiplier
// One registered signed product per cycle; result visible the next cycle.
// ----------------------------------------------------------------------------
module ddn_mul
	import ddn_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic signed [MAW-1:0] a,
	input  wire logic signed [MBW-1:0] b,
	output logic signed [MPW-1:0]      p
);

	logic signed [MPW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MPW'(a) * MPW'(b);
	end

	assign p = p_q;

endmodule
`default_nettype wire

### hw/rtl/ddn_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddn_cordic: iterative CORDIC, rotation and vectoring
// One micro-rotation per cycle for CORDIC_STEPS steps, done pulses after.
// ----------------------------------------------------------------------------
module ddn_cordic
	import ddn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cordic_ctl_t          ctl,
	input  wire logic signed [XW-1:0] x_in,
	input  wire logic signed [XW-1:0] y_in,
	input  wire logic signed [ZW-1:0] z_in,
	output logic                      busy,
	output logic                      done,
	output logic signed [XW-1:0]      x_out,
	output logic signed [XW-1:0]      y_out,
	output logic signed [ZW-1:0]      z_out
);

	logic signed [XW-1:0] x_q, y_q, xs, ys, dx, dy;
	logic signed [ZW-1:0] z_q, zs, a;
	logic                 neg_q, vec_q, negs, busy_q, done_q, sel;
	logic [4:0]           step_q;

	// argument fold at start
	always_comb begin
		xs   = x_in;
		ys   = y_in;
		zs   = '0;
		negs = 1'b0;
		if (ctl.vector_mode) begin
			if (x_in < 0) begin
				xs = -x_in;
				ys = -y_in;
				zs = (y_in >= 0) ? PI_Q16 : -PI_Q16;
			end
		end else begin
			xs = XW'(CORDIC_KINV);
			ys = '0;
			zs = z_in;
			if (z_in > HALF_PI_Q16) begin
				zs   = z_in - PI_Q16;
				negs = 1'b1;
			end else if (z_in < -HALF_PI_Q16) begin
				zs   = z_in + PI_Q16;
				negs = 1'b1;
			end
		end
	end

	// one micro-rotation
	always_comb begin
		dx  = y_q >>> step_q;
		dy  = x_q >>> step_q;
		a   = atan_q16(step_q);
		sel = vec_q ? (y_q <= 0) : (z_q >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= xs;
			y_q   <= ys;
			z_q   <= zs;
			neg_q <= negs;
			vec_q <= ctl.vector_mode;
		end else if (busy_q) begin
			if (sel) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + a;
			end
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign x_out = neg_q ? -x_q : x_q;
	assign y_out = neg_q ? -y_q : y_q;
	assign z_out = z_q;

endmodule
`default_nettype wire

### hw/rtl/diff_drive_odometry_waypoint_nav.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry_waypoint_nav: odometry and go-to-goal controller
// Integrates pose per tick, walks the route and computes wheel efforts.
// ----------------------------------------------------------------------------
// One tick is taken at a time. A tick's length is set by the shared CORDIC
// unit, one micro-rotation per cycle (once for sin/cos, once for bearing and
// distance while driving; that second pass is skipped once the route is done
// or when a waypoint error lies on an axis), and by the shared multiplier that
// serves every product in turn. A new tick is taken while the last result
// still waits; the tick after that completes once the result is taken.
// ----------------------------------------------------------------------------
module diff_drive_odometry_waypoint_nav
	import ddn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	ddn_tick_if.sink      tick,
	ddn_result_if.source  result,
	input  wire logic     cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [63:0] route_x_q, route_y_q;
	logic [15:0] dgain_q, hgain_q;
	logic [23:0] tol_q, cap_q;

	// tick state
	logic signed [15:0] fwd_q, heading_q;
	logic signed [23:0] px_q, py_q;
	logic [1:0]         tgt_q;
	logic               driving_q, reached_q, active_q;
	logic signed [11:0] held_l_q, held_r_q;
	logic [25:0]        mag_q;
	logic signed [ZW-1:0] ang_q;
	logic signed [17:0] err_q;
	logic signed [42:0] base_q;

	// result register
	logic               res_valid_q, res_reached_q, res_done_q, res_active_q;
	logic signed [11:0] res_l_q, res_r_q;
	logic signed [23:0] res_x_q, res_y_q;
	logic signed [15:0] res_h_q;

	// shared units
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [MPW-1:0] prod;
	cordic_ctl_t           cctl;
	logic signed [XW-1:0]  cx_in, cy_in, c_x, c_y;
	logic signed [ZW-1:0]  cz_in, c_z;
	logic                  c_busy, c_done;

	ddn_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	ddn_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(cctl),
		.x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
		.busy(c_busy), .done(c_done), .x_out(c_x), .y_out(c_y), .z_out(c_z)
	);

	logic tick_acc, res_free;
	assign tick.ready = (state_q == ST_IDLE);
	assign tick_acc   = tick.valid && tick.ready;
	assign res_free   = !res_valid_q || result.ready;

	// heading update
	logic signed [MPW-1:0] th_rnd;
	logic signed [16:0]    dth, mid_sum;
	logic signed [17:0]    th_raw, th_wrap;
	logic signed [15:0]    new_head, mid;
	always_comb begin
		th_rnd  = prod + (MPW'(1) <<< 14);
		dth     = th_rnd[31:15];
		th_raw  = 18'(heading_q) + 18'(dth);
		th_wrap = th_raw;
		if (th_raw > PI_WRAP) th_wrap = th_raw - TWO_PI_WRAP;
		else if (th_raw < -PI_WRAP) th_wrap = th_raw + TWO_PI_WRAP;
		if (th_wrap > 18'sd32767) new_head = 16'sh7fff;
		else if (th_wrap < -18'sd32768) new_head = 16'sh8000;
		else new_head = th_wrap[15:0];
		mid_sum = 17'(heading_q) + 17'(new_head);
		mid     = mid_sum[16:1];
	end

	// position step, shared by x and y
	logic signed [MPW-1:0] d_rnd;
	logic signed [25:0]    pos_sum, pos_base;
	logic signed [23:0]    pos_new;
	always_comb begin
		d_rnd    = prod + (MPW'(1) <<< 35);
		pos_base = (state_q == ST_MX2) ? 26'(px_q) : 26'(py_q);
		pos_sum  = pos_base + 26'($signed(d_rnd[60:36]));
		if (pos_sum > 26'sd8388607) pos_new = 24'sh7fffff;
		else if (pos_sum < -26'sd8388608) pos_new = 24'sh800000;
		else pos_new = pos_sum[23:0];
	end

	// waypoint error and window tests
	logic signed [15:0] wx_w, wy_w;
	logic signed [25:0] ex, ey, exd, eyd, tol_s;
	logic               in_x, in_y;
	always_comb begin
		wx_w  = route_x_q[16*tgt_q +: 16];
		wy_w  = route_y_q[16*tgt_q +: 16];
		ex    = (26'(wx_w) <<< 6) - 26'(px_q);
		ey    = (26'(wy_w) <<< 6) - 26'(py_q);
		tol_s = 26'(tol_q);
		in_x  = (ex < tol_s) && (ex > -tol_s);
		in_y  = (ey < tol_s) && (ey > -tol_s);
		exd   = in_x ? '0 : ex;
		eyd   = in_y ? '0 : ey;
	end

	// distance cap and bearing error
	logic [23:0]          dist_lim;
	logic signed [ZW-1:0] ang_r;
	logic signed [17:0]   err0, err1, err2;
	always_comb begin
		dist_lim = (mag_q > 26'(cap_q)) ? cap_q : mag_q[23:0];
		ang_r    = (ang_q + ZW'(4)) >>> 3;
		err0     = 18'(ang_r) - 18'(heading_q);
		err1     = (err0 < -PI_WRAP) ? err0 + TWO_PI_WRAP : err0;
		err2     = (err1 > PI_WRAP) ? err1 - TWO_PI_WRAP : err1;
	end

	// efforts
	logic signed [43:0] l_sum, r_sum;
	logic signed [11:0] l_sat, r_sat;
	always_comb begin
		l_sum = 44'(base_q) - 44'($signed(prod[42:0])) + (44'sd1 <<< 20);
		r_sum = 44'(base_q) + 44'($signed(prod[42:0])) + (44'sd1 <<< 20);
		if ((l_sum >>> 21) > 44'sd2047) l_sat = 12'sh7ff;
		else if ((l_sum >>> 21) < -44'sd2048) l_sat = 12'sh800;
		else l_sat = l_sum[32:21];
		if ((r_sum >>> 21) > 44'sd2047) r_sat = 12'sh7ff;
		else if ((r_sum >>> 21) < -44'sd2048) r_sat = 12'sh800;
		else r_sat = r_sum[32:21];
	end

	// sequencer: next state, unit operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		cctl    = '0;
		cx_in   = '0;
		cy_in   = '0;
		cz_in   = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_a = MAW'(tick.turn_rate);
				mul_b = TICK_K;
				if (tick_acc) state_d = ST_HEAD;
			end
			ST_HEAD: begin
				cctl.start = 1'b1;
				cz_in      = ZW'(mid) <<< 3;
				state_d    = ST_ROT;
			end
			ST_ROT: begin
				mul_a = c_x[MAW-1:0];
				mul_b = MBW'(fwd_q);
				if (c_done) state_d = ST_MX1;
			end
			ST_MX1: begin
				mul_a   = prod[MAW-1:0];
				mul_b   = TICK_K;
				state_d = ST_MX2;
			end
			ST_MX2: begin
				mul_a   = c_y[MAW-1:0];
				mul_b   = MBW'(fwd_q);
				state_d = ST_MY1;
			end
			ST_MY1: begin
				mul_a   = prod[MAW-1:0];
				mul_b   = TICK_K;
				state_d = ST_MY2;
			end
			ST_MY2:    state_d = ST_ARRIVE;
			ST_ARRIVE: state_d = ST_AIM;
			ST_AIM: begin
				if (!driving_q) state_d = ST_DONE;
				else if (eyd == 0 || exd == 0) state_d = ST_CAP;
				else begin
					cctl.start       = 1'b1;
					cctl.vector_mode = 1'b1;
					cx_in            = XW'(exd) <<< 20;
					cy_in            = XW'(eyd) <<< 20;
					state_d          = ST_VEC;
				end
			end
			ST_VEC: begin
				mul_a = MAW'(c_x >>> 10);
				mul_b = CORDIC_KINV;
				if (c_done) state_d = ST_MAG;
			end
			ST_MAG: state_d = ST_CAP;
			ST_CAP: begin
				mul_a   = MAW'(dist_lim);
				mul_b   = MBW'(dgain_q);
				state_d = ST_BASE;
			end
			ST_BASE: begin
				mul_a   = MAW'(err_q);
				mul_b   = MBW'(hgain_q);
				state_d = ST_TURN;
			end
			ST_TURN: state_d = ST_DONE;
			ST_DONE: if (res_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_x_q <= '0;
			route_y_q <= '0;
			dgain_q   <= 16'd1152;
			hgain_q   <= 16'd25600;
			tol_q     <= 24'd12288;
			cap_q     <= 24'd122880;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROUTE_X:   route_x_q <= cfg_data;
				CFG_ROUTE_Y:   route_y_q <= cfg_data;
				CFG_DIST_GAIN: dgain_q   <= cfg_data[15:0];
				CFG_HEAD_GAIN: hgain_q   <= cfg_data[15:0];
				CFG_ARRIVE:    tol_q     <= cfg_data[23:0];
				CFG_DIST_CAP:  cap_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			px_q      <= '0;
			py_q      <= '0;
			tgt_q     <= '0;
			driving_q <= 1'b1;
			held_l_q  <= '0;
			held_r_q  <= '0;
			reached_q <= 1'b0;
			active_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (tick_acc) begin
					reached_q <= 1'b0;
					active_q  <= 1'b0;
				end
				ST_HEAD: heading_q <= new_head;
				ST_MX2:  px_q <= pos_new;
				ST_MY2:  py_q <= pos_new;
				ST_ARRIVE: if (driving_q && in_x && in_y) begin
					if (32'(tgt_q) < ROUTE_LENGTH - 1) begin
						tgt_q     <= tgt_q + 2'd1;
						reached_q <= 1'b1;
					end else begin
						driving_q <= 1'b0;
					end
				end
				ST_TURN: begin
					held_l_q <= l_sat;
					held_r_q <= r_sat;
					active_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// drive datapath payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick_acc) fwd_q <= tick.forward_speed;
		if (state_q == ST_AIM) begin
			if (eyd == 0) begin
				mag_q <= (exd < 0) ? 26'(-exd) : 26'(exd);
				ang_q <= (exd < 0) ? PI_Q16 : '0;
			end else begin
				mag_q <= (eyd < 0) ? 26'(-eyd) : 26'(eyd);
				ang_q <= (eyd < 0) ? -HALF_PI_Q16 : HALF_PI_Q16;
			end
		end
		if (state_q == ST_MAG) begin
			mag_q <= 26'((prod + (MPW'(1) <<< 29)) >>> 30);
			ang_q <= c_z;
		end
		if (state_q == ST_CAP)  err_q  <= err2;
		if (state_q == ST_BASE) base_q <= 43'(prod[41:0]) <<< 1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (state_q == ST_DONE && res_free) res_valid_q <= 1'b1;
		else if (result.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && res_free) begin
			res_l_q       <= held_l_q;
			res_r_q       <= held_r_q;
			res_active_q  <= active_q;
			res_reached_q <= reached_q;
			res_done_q    <= !driving_q;
			res_x_q       <= px_q;
			res_y_q       <= py_q;
			res_h_q       <= heading_q;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.left_effort      = res_l_q;
	assign result.right_effort     = res_r_q;
	assign result.drive_active     = res_active_q;
	assign result.waypoint_reached = res_reached_q;
	assign result.route_done       = res_done_q;
	assign result.pose_x           = res_x_q;
	assign result.pose_y           = res_y_q;
	assign result.pose_heading     = res_h_q;

`ifndef ASSERT_OFF
	// once the route is done it stays done
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!driving_q |=> !driving_q) else $error("driving set again after route end");

	// target index only ever steps up by one
	a_tgt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tgt_q != $past(tgt_q)) |-> (tgt_q == $past(tgt_q) + 2'd1))
		else $error("target index jumped");

	// the CORDIC unit is never busy while waiting for a tick
	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !c_busy) else $error("CORDIC busy in idle");

	// a finished route never reports a recomputed effort
	a_done_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.route_done && result.drive_active))
		else $error("effort recomputed after route end");
`endif

endmodule
`default_nettype wire
